// ===== rtl/crc_pkg.sv =====
// Shared constants for the midpoint circle rasterizer.
package crc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int COLOR_BITS     = 4;
  localparam int DEC_BITS       = 16;

  localparam int DEC_INIT     = 3;
  localparam int DEC_STEP_INC = 6;
  localparam int DEC_DIAG_INC = 10;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  localparam int OUTLINE_RESULTS = 8;
  localparam int FILL_RESULTS    = 4;
  localparam int QUEUE_DEPTH     = 2;

endpackage

// ===== rtl/crc_ifs.sv =====
// Request and result channel interfaces of the midpoint circle rasterizer.
interface crc_in_if import crc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic        [COORD_BITS-2:0] radius;
  logic        [COLOR_BITS-1:0] color;
  logic                         filled;

  modport source (output valid, mode, center_x, center_y, radius, color, filled,
                  input ready);
  modport sink (input valid, mode, center_x, center_y, radius, color, filled,
                output ready);
endinterface

interface crc_out_if import crc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] x_start;
  logic signed [COORD_BITS:0] x_end;
  logic signed [COORD_BITS:0] row;
  logic      [COLOR_BITS-1:0] pixel_color;
  logic                       last_of_step;
  logic                       figure_done;

  modport source (output valid, x_start, x_end, row, pixel_color, last_of_step,
                  figure_done, input ready);
  modport sink (input valid, x_start, x_end, row, pixel_color, last_of_step,
                figure_done, output ready);
endinterface

// ===== rtl/crc_front.sv =====
// Front end: accepts requests, holds the circle state and issues step descriptors.
module crc_front import crc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int STEP_W     = 4 * COORD_BITS_DEF + COLOR_BITS + 2
) (
  input  logic              clk,
  input  logic              rst_n,
  crc_in_if.sink            in_ch,
  input  logic              q_full,
  output logic              q_push,
  output logic [STEP_W-1:0] q_data
);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic        [COORD_BITS-1:0] x;
    logic        [COORD_BITS-1:0] y;
    logic        [COLOR_BITS-1:0] color;
    logic                         fill;
    logic                         done;
  } step_t;

  logic                         active_r, active_nxt;
  logic signed [COORD_BITS-1:0] cx_r, cx_nxt;
  logic signed [COORD_BITS-1:0] cy_r, cy_nxt;
  logic        [COORD_BITS-1:0] x_r, x_nxt;
  logic        [COORD_BITS-1:0] y_r, y_nxt;
  logic          [DEC_BITS-1:0] dec_r, dec_nxt;
  logic        [COLOR_BITS-1:0] color_r, color_nxt;
  logic                         fill_r, fill_nxt;

  logic                         accept;
  logic        [COORD_BITS-1:0] x_step;
  logic        [COORD_BITS-1:0] y_step;
  logic          [DEC_BITS-1:0] dec_step;
  logic                         done_step;
  step_t                        desc;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    x_step = x_r + 1'b1;
    if (dec_r[DEC_BITS-1]) begin
      y_step   = y_r;
      dec_step = dec_r + (DEC_BITS'(x_r) << 2) + DEC_BITS'(DEC_STEP_INC);
    end else begin
      y_step   = y_r - 1'b1;
      dec_step = dec_r + ((DEC_BITS'(x_r) - DEC_BITS'(y_r)) << 2) + DEC_BITS'(DEC_DIAG_INC);
    end
    done_step = y_step < x_step;
  end

  always_comb begin
    desc.cx    = cx_r;
    desc.cy    = cy_r;
    desc.x     = x_r;
    desc.y     = y_r;
    desc.color = color_r;
    desc.fill  = fill_r;
    desc.done  = done_step;
  end

  assign q_push = accept && (in_ch.mode == MODE_STEP) && active_r;
  assign q_data = desc;

  always_comb begin
    active_nxt = active_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    dec_nxt    = dec_r;
    color_nxt  = color_r;
    fill_nxt   = fill_r;
    if (accept && (in_ch.mode == MODE_START)) begin
      cx_nxt     = in_ch.center_x;
      cy_nxt     = in_ch.center_y;
      x_nxt      = '0;
      y_nxt      = {1'b0, in_ch.radius};
      dec_nxt    = DEC_BITS'(DEC_INIT) - (DEC_BITS'(in_ch.radius) << 1);
      color_nxt  = in_ch.color;
      fill_nxt   = in_ch.filled;
      active_nxt = (in_ch.radius != '0);
    end else if (q_push) begin
      x_nxt   = x_step;
      y_nxt   = y_step;
      dec_nxt = dec_step;
      if (done_step) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cx_r     <= '0;
      cy_r     <= '0;
      x_r      <= '0;
      y_r      <= '0;
      dec_r    <= '0;
      color_r  <= '0;
      fill_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      dec_r    <= dec_nxt;
      color_r  <= color_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// ===== rtl/crc_queue.sv =====
// Short first-in first-out queue of step descriptors between front and back.
module crc_queue import crc_pkg::*; #(
  parameter int WIDTH = 4 * COORD_BITS_DEF + COLOR_BITS + 2,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/crc_back.sv =====
// Back end: expands one step descriptor into its points or spans, one per cycle while the output is not stalled.
module crc_back import crc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int STEP_W     = 4 * COORD_BITS_DEF + COLOR_BITS + 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  logic [STEP_W-1:0] q_data,
  crc_out_if.source         out_ch
);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic        [COORD_BITS-1:0] x;
    logic        [COORD_BITS-1:0] y;
    logic        [COLOR_BITS-1:0] color;
    logic                         fill;
    logic                         done;
  } step_t;

  localparam int IDX_W = $clog2(OUTLINE_RESULTS);

  step_t                      cur_r, cur_nxt;
  logic                       cur_vld_r, cur_vld_nxt;
  logic           [IDX_W-1:0] idx_r, idx_nxt;

  logic                       out_vld_r;
  logic signed [COORD_BITS:0] xs_r, xe_r, row_r;
  logic      [COLOR_BITS-1:0] color_r;
  logic                       last_r, done_r;

  logic                       out_free;
  logic                       emit;
  logic                       is_last;
  logic           [IDX_W-1:0] last_idx;
  logic                       col_use_y, col_neg, row_use_y, row_neg;
  logic      [COORD_BITS-1:0] col_val, row_val;
  logic signed [COORD_BITS:0] cx_e, cy_e, col_e, row_e;
  logic signed [COORD_BITS:0] col_plus, col_minus, row_sel;
  logic signed [COORD_BITS:0] xs_sel, xe_sel;

  assign out_free = !out_vld_r || out_ch.ready;
  assign emit     = cur_vld_r && out_free;
  assign last_idx = cur_r.fill ? IDX_W'(FILL_RESULTS - 1) : IDX_W'(OUTLINE_RESULTS - 1);
  assign is_last  = (idx_r == last_idx);
  assign q_ready  = !cur_vld_r || (emit && is_last);

  always_comb begin
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    idx_nxt     = idx_r;
    if (q_valid && q_ready) begin
      cur_nxt     = step_t'(q_data);
      cur_vld_nxt = 1'b1;
      idx_nxt     = '0;
    end else if (emit && is_last) begin
      cur_vld_nxt = 1'b0;
      idx_nxt     = '0;
    end else if (emit) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_comb begin
    col_use_y = 1'b0;
    col_neg   = 1'b0;
    row_use_y = 1'b1;
    row_neg   = 1'b1;
    if (cur_r.fill) begin
      case (idx_r)
        IDX_W'(0): begin col_use_y = 1'b0; row_use_y = 1'b1; row_neg = 1'b1; end
        IDX_W'(1): begin col_use_y = 1'b1; row_use_y = 1'b0; row_neg = 1'b1; end
        IDX_W'(2): begin col_use_y = 1'b0; row_use_y = 1'b1; row_neg = 1'b0; end
        IDX_W'(3): begin col_use_y = 1'b1; row_use_y = 1'b0; row_neg = 1'b0; end
        default: begin
          col_use_y = 1'b0;
          row_use_y = 1'b1;
          row_neg   = 1'b1;
        end
      endcase
    end else begin
      case (idx_r)
        IDX_W'(0): begin col_use_y = 1'b0; col_neg = 1'b0; row_use_y = 1'b1; row_neg = 1'b1; end
        IDX_W'(1): begin col_use_y = 1'b1; col_neg = 1'b0; row_use_y = 1'b0; row_neg = 1'b1; end
        IDX_W'(2): begin col_use_y = 1'b1; col_neg = 1'b0; row_use_y = 1'b0; row_neg = 1'b0; end
        IDX_W'(3): begin col_use_y = 1'b0; col_neg = 1'b0; row_use_y = 1'b1; row_neg = 1'b0; end
        IDX_W'(4): begin col_use_y = 1'b0; col_neg = 1'b1; row_use_y = 1'b1; row_neg = 1'b0; end
        IDX_W'(5): begin col_use_y = 1'b1; col_neg = 1'b1; row_use_y = 1'b0; row_neg = 1'b0; end
        IDX_W'(6): begin col_use_y = 1'b1; col_neg = 1'b1; row_use_y = 1'b0; row_neg = 1'b1; end
        default: begin
          col_use_y = 1'b0;
          col_neg   = 1'b1;
          row_use_y = 1'b1;
          row_neg   = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    col_val   = col_use_y ? cur_r.y : cur_r.x;
    row_val   = row_use_y ? cur_r.y : cur_r.x;
    cx_e      = {cur_r.cx[COORD_BITS-1], cur_r.cx};
    cy_e      = {cur_r.cy[COORD_BITS-1], cur_r.cy};
    col_e     = {1'b0, col_val};
    row_e     = {1'b0, row_val};
    col_plus  = cx_e + col_e;
    col_minus = cx_e - col_e;
    row_sel   = row_neg ? (cy_e - row_e) : (cy_e + row_e);
    if (cur_r.fill) begin
      xs_sel = col_minus;
      xe_sel = col_plus;
    end else begin
      xs_sel = col_neg ? col_minus : col_plus;
      xe_sel = xs_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      idx_r     <= idx_nxt;
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) begin
      xs_r    <= xs_sel;
      xe_r    <= xe_sel;
      row_r   <= row_sel;
      color_r <= cur_r.color;
      last_r  <= is_last;
      done_r  <= is_last && cur_r.done;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.x_start      = xs_r;
  assign out_ch.x_end        = xe_r;
  assign out_ch.row          = row_r;
  assign out_ch.pixel_color  = color_r;
  assign out_ch.last_of_step = last_r;
  assign out_ch.figure_done  = done_r;

endmodule

// ===== rtl/midpoint_circle_rasterizer.sv =====
// Top level of the midpoint circle rasterizer.
// A start request loads the center, radius, color and fill flag and gives no
// result; each step request advances the midpoint circle by one octant step and
// gives eight points in outline mode or four horizontal spans in filled mode,
// with last_of_step on the final one and figure_done on the final result of the
// circle. The output register delivers one result per cycle while the output
// channel is ready; the front end runs ahead through a two-entry descriptor
// queue and keeps accepting requests while the back end is busy until both
// entries are taken, and the first result of a step passes through the queue,
// the back end's current-descriptor register and the output register in turn.
module midpoint_circle_rasterizer import crc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  crc_in_if.sink     in_ch,
  crc_out_if.source  out_ch
);

  localparam int STEP_W = 4 * COORD_BITS + COLOR_BITS + 2;

  logic              q_push;
  logic              q_full;
  logic [STEP_W-1:0] q_push_data;
  logic              q_valid;
  logic              q_ready;
  logic [STEP_W-1:0] q_pop_data;

  crc_front #(
    .COORD_BITS (COORD_BITS),
    .STEP_W     (STEP_W)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_push_data)
  );

  crc_queue #(
    .WIDTH (STEP_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_pop_data)
  );

  crc_back #(
    .COORD_BITS (COORD_BITS),
    .STEP_W     (STEP_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_pop_data),
    .out_ch  (out_ch)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("step descriptor pushed into a full queue");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.figure_done) |-> out_ch.last_of_step)
    else $error("figure_done without last_of_step");

  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ($signed(out_ch.x_start) <= $signed(out_ch.x_end)))
    else $error("span left end lies right of its right end");

  a_push_only_step: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (in_ch.valid && in_ch.ready && (in_ch.mode == MODE_STEP)))
    else $error("descriptor pushed without an accepted step request");

endmodule
